// ----- design/uvf_pkg.sv -----
// ----------------------------------------------------------------------------
// uvf_pkg
// Shared types and constants for the unique-value FIFO and its storage cells.
// ----------------------------------------------------------------------------
package uvf_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int DATA_W        = 32;
   localparam int OCC_W         = 5;

   typedef enum logic {
      REQ_PUSH = 1'b0,
      REQ_POP  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_DUP   = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Broadcast from the control logic to every cell in the row.
   typedef struct packed {
      logic              push_en;
      logic              pop_en;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ----- design/uvf_cell.sv -----
// ----------------------------------------------------------------------------
// uvf_cell
// One storage slot of the FIFO: holds a word and its valid bit, compares the
// pushed word against its own, loads at the tail and shifts toward the head.
// ----------------------------------------------------------------------------
module uvf_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  uvf_pkg::cell_ctrl_type ctrl,
   input  logic                   prev_valid,
   input  logic                   next_valid,
   input  logic [uvf_pkg::DATA_W-1:0] next_value,
   output logic                   valid,
   output logic [uvf_pkg::DATA_W-1:0] value,
   output logic                   match
);
   import uvf_pkg::*;

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] value_ff, value_in;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.pop_en) begin
         valid_in = next_valid;
         value_in = next_value;
      end else if (ctrl.push_en && !valid_ff && prev_valid) begin
         // first empty slot is the tail
         valid_in = 1'b1;
         value_in = ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign match = valid_ff && (value_ff == ctrl.value);

endmodule

// ----- design/unique_value_fifo.sv -----
// ----------------------------------------------------------------------------
// unique_value_fifo
// FIFO of signed 32-bit words that rejects a push of a word already queued.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH cells with the head in cell 0. Each request
// (push or pop) is served thus: every cell compares its word with the pushed
// word in parallel, a push loads the first empty cell, and a pop shifts every
// cell one place toward the head. One result word per request comes out of an
// output register, so a new request is accepted every cycle while rsp_ready
// holds. A push to a full queue reports full even if the word is a duplicate;
// popped_value is zero for every request other than a successful pop.
// ----------------------------------------------------------------------------
module unique_value_fifo #(
   parameter int DEPTH = uvf_pkg::DEFAULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic signed [uvf_pkg::DATA_W-1:0] req_push_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic signed [uvf_pkg::DATA_W-1:0] rsp_popped_value,
   output logic [uvf_pkg::OCC_W-1:0]         rsp_occupancy,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full
);
   import uvf_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   cell_ctrl_type     ctrl;
   logic [DEPTH-1:0]  valid_vec;
   logic [DEPTH-1:0]  match_vec;
   logic [DATA_W-1:0] cell_value [DEPTH];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] popped_ff, popped_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic              empty_ff, empty_in;
   logic              full_ff, full_in;

   logic accept, is_full, is_empty, dup;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign dup       = |match_vec;

   always_comb begin
      ctrl.value   = req_push_value;
      ctrl.push_en = 1'b0;
      ctrl.pop_en  = 1'b0;
      status_in    = ST_DONE;
      popped_in    = '0;
      count_in     = count_ff;
      if (req_kind_type'(req_type) == REQ_PUSH) begin
         if (is_full) begin
            status_in = ST_FULL;
         end else if (dup) begin
            status_in = ST_DUP;
         end else begin
            ctrl.push_en = accept;
            count_in     = count_ff + CNT_W'(1);
         end
      end else begin
         if (is_empty) begin
            status_in = ST_EMPTY;
         end else begin
            ctrl.pop_en = accept;
            popped_in   = cell_value[0];
            count_in    = count_ff - CNT_W'(1);
         end
      end
      occ_in   = OCC_W'(count_in);
      empty_in = (count_in == '0);
      full_in  = (count_in == CNT_W'(DEPTH));
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic              prev_v, next_v;
      logic [DATA_W-1:0] next_d;
      if (i == 0) begin : g_head
         assign prev_v = 1'b1;
      end else begin : g_body
         assign prev_v = valid_vec[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign next_v = 1'b0;
         assign next_d = '0;
      end else begin : g_inner
         assign next_v = valid_vec[i+1];
         assign next_d = cell_value[i+1];
      end
      uvf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_valid (prev_v),
         .next_valid (next_v),
         .next_value (next_d),
         .valid      (valid_vec[i]),
         .value      (cell_value[i]),
         .match      (match_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
         occ_ff    <= occ_in;
         empty_ff  <= empty_in;
         full_ff   <= full_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_occupancy    = occ_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_is_full      = full_ff;

   // valid bits track the count
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("cell valid bits disagree with count");

   // valid cells are contiguous from the head
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + DEPTH'(1))) == '0)
      else $error("gap in valid cells");

   // a rejected request never returns a word
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |-> rsp_popped_value == '0)
      else $error("rejected request returned data");

   // a successful pop shrinks the queue by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      accept && ctrl.pop_en |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not decrement count");

endmodule
